/* sv/ebmsf_pkg.sv */
// Shared types and constants for the edge bounded min/max snap filter.
package ebmsf_pkg;

   localparam int PAD_DEF       = 4;
   localparam int MAX_WIDTH_DEF = 2048;
   localparam int HEIGHT_MAX    = 4096;

   localparam logic [11:0] WIDTH_RESET  = 12'd640;
   localparam logic [12:0] HEIGHT_RESET = 13'd480;

   localparam logic ITEM_PIXEL = 1'b0;
   localparam logic ITEM_FLUSH = 1'b1;

   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic [7:0] PIX_MAX = 8'd255;

   typedef struct packed {
      logic       req_type;
      logic [7:0] prob_value;
      logic       edge_flag;
   } ebmsf_req_type;

   typedef struct packed {
      logic [7:0]  pixel_out;
      logic [11:0] out_row;
      logic [10:0] out_col;
      logic        frame_end;
   } ebmsf_rsp_type;

   typedef struct packed {
      logic [11:0] row;
      logic [10:0] col;
      logic        last;
      logic        border;
   } ebmsf_ctl_type;

endpackage

/* sv/ebmsf_line_store.sv */
// Banked line store: one bank per buffered row, one write and two registered reads.
module ebmsf_line_store #(
   parameter int PAD       = ebmsf_pkg::PAD_DEF,
   parameter int MAX_WIDTH = ebmsf_pkg::MAX_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [$clog2(2*PAD+1)-1:0]           wr_bank,
   input  logic [$clog2(MAX_WIDTH)-1:0]         wr_col,
   input  logic [8:0]                           wr_data,
   input  logic                                 rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]         rd_col_a,
   input  logic [$clog2(MAX_WIDTH)-1:0]         rd_col_b,
   output logic [2*PAD:0][8:0]                  rd_a,
   output logic [2*PAD:0][8:0]                  rd_b
);
   localparam int ROWS = 2 * PAD + 1;
   localparam int BW   = $clog2(ROWS);

   for (genvar b = 0; b < ROWS; b++) begin : g_bank
      logic [8:0] mem [MAX_WIDTH];
      logic [8:0] rd_a_ff;
      logic [8:0] rd_b_ff;

      always_ff @(posedge clock) begin
         if (wr_en && (wr_bank == BW'(b))) begin
            mem[wr_col] <= wr_data;
         end
         if (rd_en) begin
            rd_a_ff <= mem[rd_col_a];
            rd_b_ff <= mem[rd_col_b];
         end
      end

      assign rd_a[b] = rd_a_ff;
      assign rd_b[b] = rd_b_ff;
   end

endmodule

/* sv/edge_bounded_minmax_snap_filter.sv */
// Top level of the edge bounded min/max snap filter.
//
// Usage:
//  req_* : raster-order pixel requests (prob_value, edge_flag) and flush requests,
//          taken when req_valid is high and req_stall is low.
//  rsp_* : filtered pixels with row, column and frame_end, taken when rsp_valid
//          is high and rsp_stall is low.
//  csr_* : frame_width (index 0) and frame_height (index 1); csr_ready is always
//          high and a write restarts the frame. Write only while idle.
//  Output lags the input by PAD rows and PAD columns; after the last pixel of a
//  frame, one flush request per pending output drains the frame.
//  Throughput: one request per cycle while req_stall is low. A request that
//  produces a result shows it on rsp_valid after the store read, window, arm
//  search, min/max/sum tree, two divider stages and output register.
//  The line store is 2*PAD+1 banks of MAX_WIDTH entries, one write and two
//  reads per cycle; it is not cleared at reset.
//  Reset clears all counters and pipeline valids, sets the frame to 640x480.
//  While the receiver stalls, the pipeline holds; empty stages still fill, and
//  req_stall rises only when every stage holds a result.
module edge_bounded_minmax_snap_filter #(
   parameter int PAD       = ebmsf_pkg::PAD_DEF,
   parameter int MAX_WIDTH = ebmsf_pkg::MAX_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ebmsf_pkg::ebmsf_req_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ebmsf_pkg::ebmsf_rsp_type rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [12:0]              csr_wdata
);
   import ebmsf_pkg::*;

   localparam int ROWS = 2 * PAD + 1;
   localparam int BW   = $clog2(ROWS);
   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int PW   = $clog2(MAX_WIDTH * HEIGHT_MAX + 1);
   localparam int NL   = 2 * ROWS;
   localparam int LEAF = 2 ** $clog2(NL);
   localparam int KW   = $clog2(NL + 1);
   localparam int SW   = $clog2(255 * NL + 1);
   localparam int DW   = SW + 8;

   // configuration
   logic [11:0] fw_ff;
   logic [12:0] fh_ff;
   logic        csr_restart;

   assign csr_ready   = 1'b1;
   assign csr_restart = csr_valid &&
                        ((csr_index == CSR_FRAME_WIDTH) || (csr_index == CSR_FRAME_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= WIDTH_RESET;
         fh_ff <= HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  fw_ff <= csr_wdata[11:0];
            CSR_FRAME_HEIGHT: fh_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [WW-1:0] w_eff;
   logic [12:0]   h_eff;
   logic [CW-1:0] wm1;
   logic [11:0]   hm1;
   logic [PW-1:0] thresh;

   always_comb begin
      if (fw_ff == 12'd0) begin
         w_eff = WW'(1);
      end else if (13'(fw_ff) > 13'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(fw_ff);
      end
      if (fh_ff == 13'd0) begin
         h_eff = 13'd1;
      end else if (fh_ff > 13'(HEIGHT_MAX)) begin
         h_eff = 13'(HEIGHT_MAX);
      end else begin
         h_eff = fh_ff;
      end
   end

   assign wm1    = CW'(w_eff - WW'(1));
   assign hm1    = 12'(h_eff - 13'd1);
   assign thresh = PW'(PAD) * (PW'(w_eff) + PW'(1));

   // position counters
   logic [11:0]   in_row_ff, in_row_in, em_row_ff, em_row_in;
   logic [CW-1:0] in_col_ff, in_col_in, em_col_ff, em_col_in;
   logic [BW-1:0] in_bank_ff, in_bank_in, em_bank_ff, em_bank_in;
   logic          in_done_ff, in_done_in;
   logic [PW-1:0] pend_ff, pend_in, pend_st;

   logic accept, is_pix, store, emit, last_in, last_out, border;
   logic [CW:0]   cb_sum;
   logic [CW-1:0] col_b;
   logic s1_free;

   assign accept   = req_valid && !req_stall;
   assign is_pix   = req_data.req_type == ITEM_PIXEL;
   assign store    = accept && is_pix && !in_done_ff;
   assign last_in  = (in_row_ff == hm1) && (in_col_ff == wm1);
   assign last_out = (em_row_ff == hm1) && (em_col_ff == wm1);
   assign pend_st  = pend_ff + PW'(store);
   assign emit     = (store && (pend_st > thresh)) ||
                     (accept && (req_data.req_type == ITEM_FLUSH) && in_done_ff &&
                      (pend_ff != '0));
   assign border   = (em_row_ff < 12'(PAD)) || (em_col_ff < CW'(PAD)) ||
                     ((13'(em_row_ff) + 13'(PAD)) >= h_eff) ||
                     (((WW+1)'(em_col_ff) + (WW+1)'(PAD)) >= {1'b0, w_eff});
   assign cb_sum   = (CW+1)'(em_col_ff) + (CW+1)'(PAD);
   assign col_b    = (cb_sum >= (CW+1)'(MAX_WIDTH)) ? '0 : cb_sum[CW-1:0];

   always_comb begin
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      in_bank_in = in_bank_ff;
      in_done_in = in_done_ff;
      em_row_in  = em_row_ff;
      em_col_in  = em_col_ff;
      em_bank_in = em_bank_ff;
      pend_in    = pend_st - PW'(emit);
      if (store) begin
         if (last_in) begin
            in_done_in = 1'b1;
         end else if (in_col_ff == wm1) begin
            in_col_in  = '0;
            in_row_in  = in_row_ff + 12'd1;
            in_bank_in = (in_bank_ff == BW'(ROWS - 1)) ? '0 : in_bank_ff + BW'(1);
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end
      end
      if (emit) begin
         if (last_out) begin
            em_col_in  = '0;
            em_row_in  = '0;
            em_bank_in = '0;
         end else if (em_col_ff == wm1) begin
            em_col_in  = '0;
            em_row_in  = em_row_ff + 12'd1;
            em_bank_in = (em_bank_ff == BW'(ROWS - 1)) ? '0 : em_bank_ff + BW'(1);
         end else begin
            em_col_in = em_col_ff + CW'(1);
         end
      end
      if ((emit && last_out) || csr_restart) begin
         in_row_in  = '0;
         in_col_in  = '0;
         in_bank_in = '0;
         in_done_in = 1'b0;
         em_row_in  = '0;
         em_col_in  = '0;
         em_bank_in = '0;
         pend_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         in_bank_ff <= '0;
         in_done_ff <= 1'b0;
         em_row_ff  <= '0;
         em_col_ff  <= '0;
         em_bank_ff <= '0;
         pend_ff    <= '0;
      end else begin
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         in_bank_ff <= in_bank_in;
         in_done_ff <= in_done_in;
         em_row_ff  <= em_row_in;
         em_col_ff  <= em_col_in;
         em_bank_ff <= em_bank_in;
         pend_ff    <= pend_in;
      end
   end

   // stage 1: line store read
   logic [ROWS-1:0][8:0] rd_a, rd_b;

   ebmsf_line_store #(
      .PAD       (PAD),
      .MAX_WIDTH (MAX_WIDTH)
   ) u_store (
      .clock    (clock),
      .wr_en    (store),
      .wr_bank  (in_bank_ff),
      .wr_col   (in_col_ff),
      .wr_data  ({req_data.edge_flag, req_data.prob_value}),
      .rd_en    (emit),
      .rd_col_a (em_col_ff),
      .rd_col_b (col_b),
      .rd_a     (rd_a),
      .rd_b     (rd_b)
   );

   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, s6_v_ff, rsp_valid_ff;
   logic s2_free, s3_free, s4_free, s5_free, s6_free, out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s6_free   = !s6_v_ff || out_free;
   assign s5_free   = !s5_v_ff || s6_free;
   assign s4_free   = !s4_v_ff || s5_free;
   assign s3_free   = !s3_v_ff || s4_free;
   assign s2_free   = !s2_v_ff || s3_free;
   assign s1_free   = !s1_v_ff || s2_free;
   assign req_stall = !s1_free;

   ebmsf_ctl_type s1_ctl_ff, s2_ctl_ff, s3_ctl_ff, s4_ctl_ff, s5_ctl_ff, s6_ctl_ff;
   logic [BW-1:0] s1_bank_ff;

   always_ff @(posedge clock) begin
      if (accept && s1_free) begin
         s1_ctl_ff.row    <= em_row_ff;
         s1_ctl_ff.col    <= 11'(em_col_ff);
         s1_ctl_ff.last   <= last_out;
         s1_ctl_ff.border <= border;
         s1_bank_ff       <= em_bank_ff;
      end
   end

   // stage 2: cross window from vertical reads and horizontal chains
   logic [PAD-1:0][8:0]  hist_ff, hist_in, look_ff, look_in;
   logic [ROWS-1:0][8:0] hwin_in, hwin_ff, vert_in, vert_ff;
   logic [BW+1:0]        vsel [ROWS];

   always_comb begin
      for (int k = 0; k < ROWS; k++) begin
         vsel[k] = (BW+2)'(s1_bank_ff) + (BW+2)'(k + ROWS - PAD);
         if (vsel[k] >= (BW+2)'(ROWS)) vsel[k] = vsel[k] - (BW+2)'(ROWS);
         if (vsel[k] >= (BW+2)'(ROWS)) vsel[k] = vsel[k] - (BW+2)'(ROWS);
         vert_in[k] = rd_a[vsel[k][BW-1:0]];
      end
      for (int k = 0; k < PAD; k++) begin
         hwin_in[k]       = hist_ff[k];
         hwin_in[PAD + k] = look_ff[k];
      end
      hwin_in[2*PAD] = rd_b[s1_bank_ff];
      for (int k = 0; k < PAD - 1; k++) begin
         hist_in[k] = hist_ff[k+1];
         look_in[k] = look_ff[k+1];
      end
      hist_in[PAD-1] = rd_a[s1_bank_ff];
      look_in[PAD-1] = rd_b[s1_bank_ff];
   end

   always_ff @(posedge clock) begin
      if (s1_v_ff && s2_free) begin
         hist_ff   <= hist_in;
         look_ff   <= look_in;
         hwin_ff   <= hwin_in;
         vert_ff   <= vert_in;
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   // stage 3: arm search and span masks
   logic [BW-1:0] lo_h, hi_h, lo_v, hi_v;
   logic          fl, fr, fu, fd, use_x, use_y;
   logic [NL-1:0] mask_in, s3_mask_ff;
   logic [NL-1:0][7:0] val_in, s3_val_ff;
   logic          s3_pass_ff;
   logic [7:0]    s3_centre_ff;

   always_comb begin
      lo_h = '0;
      hi_h = BW'(2 * PAD);
      lo_v = '0;
      hi_v = BW'(2 * PAD);
      fl   = 1'b0;
      fr   = 1'b0;
      fu   = 1'b0;
      fd   = 1'b0;
      for (int d = PAD; d >= 0; d--) begin
         if (hwin_ff[PAD-d][8]) begin fl = 1'b1; lo_h = BW'(PAD - d); end
         if (hwin_ff[PAD+d][8]) begin fr = 1'b1; hi_h = BW'(PAD + d); end
         if (vert_ff[PAD-d][8]) begin fu = 1'b1; lo_v = BW'(PAD - d); end
         if (vert_ff[PAD+d][8]) begin fd = 1'b1; hi_v = BW'(PAD + d); end
      end
      use_x = fl || fr;
      use_y = fu || fd;
      for (int k = 0; k < ROWS; k++) begin
         mask_in[k]        = use_x && (BW'(k) >= lo_h) && (BW'(k) <= hi_h);
         mask_in[ROWS + k] = use_y && (BW'(k) >= lo_v) && (BW'(k) <= hi_v);
         val_in[k]         = hwin_ff[k][7:0];
         val_in[ROWS + k]  = vert_ff[k][7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (s2_v_ff && s3_free) begin
         s3_mask_ff   <= mask_in;
         s3_val_ff    <= val_in;
         s3_pass_ff   <= s2_ctl_ff.border || !(use_x || use_y);
         s3_centre_ff <= vert_ff[PAD][7:0];
         s3_ctl_ff    <= s2_ctl_ff;
      end
   end

   // stage 4: min, max and sum trees
   logic [7:0]    mn_t [1:2*LEAF-1];
   logic [7:0]    mx_t [1:2*LEAF-1];
   logic [SW-1:0] sm_t [1:2*LEAF-1];
   logic [7:0]    s4_mn_ff, s4_mx_ff, s4_centre_ff;
   logic [SW-1:0] s4_sum_ff;
   logic [KW-1:0] s4_cnt_ff;
   logic          s4_pass_ff;

   always_comb begin
      for (int i = 0; i < LEAF; i++) begin
         if ((i < NL) && s3_mask_ff[i % NL]) begin
            mn_t[LEAF+i] = s3_val_ff[i % NL];
            mx_t[LEAF+i] = s3_val_ff[i % NL];
            sm_t[LEAF+i] = SW'(s3_val_ff[i % NL]);
         end else begin
            mn_t[LEAF+i] = PIX_MAX;
            mx_t[LEAF+i] = '0;
            sm_t[LEAF+i] = '0;
         end
      end
      for (int i = LEAF - 1; i >= 1; i--) begin
         mn_t[i] = (mn_t[2*i] < mn_t[2*i+1]) ? mn_t[2*i] : mn_t[2*i+1];
         mx_t[i] = (mx_t[2*i] > mx_t[2*i+1]) ? mx_t[2*i] : mx_t[2*i+1];
         sm_t[i] = sm_t[2*i] + sm_t[2*i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (s3_v_ff && s4_free) begin
         s4_mn_ff     <= mn_t[1];
         s4_mx_ff     <= mx_t[1];
         s4_sum_ff    <= sm_t[1];
         s4_cnt_ff    <= KW'($countones(s3_mask_ff));
         s4_pass_ff   <= s3_pass_ff;
         s4_centre_ff <= s3_centre_ff;
         s4_ctl_ff    <= s3_ctl_ff;
      end
   end

   // stage 5: quotient bits 7..4
   logic [DW-1:0] rem_h, rem_l;
   logic [3:0]    q_h, q_l;
   logic [SW-1:0] s5_rem_ff;
   logic [3:0]    s5_qh_ff;
   logic [7:0]    s5_mn_ff, s5_mx_ff, s5_centre_ff;
   logic [KW-1:0] s5_cnt_ff;
   logic          s5_pass_ff;

   always_comb begin
      rem_h = DW'(s4_sum_ff);
      q_h   = '0;
      for (int i = 3; i >= 0; i--) begin
         if (rem_h >= (DW'(s4_cnt_ff) << (i + 4))) begin
            rem_h  = rem_h - (DW'(s4_cnt_ff) << (i + 4));
            q_h[i] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s4_v_ff && s5_free) begin
         s5_rem_ff    <= SW'(rem_h);
         s5_qh_ff     <= q_h;
         s5_cnt_ff    <= s4_cnt_ff;
         s5_mn_ff     <= s4_mn_ff;
         s5_mx_ff     <= s4_mx_ff;
         s5_pass_ff   <= s4_pass_ff;
         s5_centre_ff <= s4_centre_ff;
         s5_ctl_ff    <= s4_ctl_ff;
      end
   end

   // stage 6: quotient bits 3..0
   logic [7:0] s6_avg_ff, s6_mn_ff, s6_mx_ff, s6_centre_ff;
   logic       s6_pass_ff;

   always_comb begin
      rem_l = DW'(s5_rem_ff);
      q_l   = '0;
      for (int i = 3; i >= 0; i--) begin
         if (rem_l >= (DW'(s5_cnt_ff) << i)) begin
            rem_l  = rem_l - (DW'(s5_cnt_ff) << i);
            q_l[i] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s5_v_ff && s6_free) begin
         s6_avg_ff    <= {s5_qh_ff, q_l};
         s6_mn_ff     <= s5_mn_ff;
         s6_mx_ff     <= s5_mx_ff;
         s6_pass_ff   <= s5_pass_ff;
         s6_centre_ff <= s5_centre_ff;
         s6_ctl_ff    <= s5_ctl_ff;
      end
   end

   // output register: snap to min or max, or pass the centre pixel through
   ebmsf_rsp_type rsp_in, rsp_data_ff;

   always_comb begin
      if (s6_pass_ff) begin
         rsp_in.pixel_out = s6_centre_ff;
      end else if ((s6_mx_ff - s6_avg_ff) > (s6_avg_ff - s6_mn_ff)) begin
         rsp_in.pixel_out = s6_mn_ff;
      end else begin
         rsp_in.pixel_out = s6_mx_ff;
      end
      rsp_in.out_row   = s6_ctl_ff.row;
      rsp_in.out_col   = s6_ctl_ff.col;
      rsp_in.frame_end = s6_ctl_ff.last;
   end

   always_ff @(posedge clock) begin
      if (s6_v_ff && out_free) begin
         rsp_data_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         s4_v_ff      <= 1'b0;
         s5_v_ff      <= 1'b0;
         s6_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free)  s1_v_ff      <= emit;
         if (s2_free)  s2_v_ff      <= s1_v_ff;
         if (s3_free)  s3_v_ff      <= s2_v_ff;
         if (s4_free)  s4_v_ff      <= s3_v_ff;
         if (s5_free)  s5_v_ff      <= s4_v_ff;
         if (s6_free)  s6_v_ff      <= s5_v_ff;
         if (out_free) rsp_valid_ff <= s6_v_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= thresh + PW'(1))
      else $error("pending count above the output lag");

   a_done_pos: assert property (@(posedge clock) disable iff (reset)
      in_done_ff |-> ((in_row_ff == hm1) && (in_col_ff == wm1)))
      else $error("input marked complete away from the last pixel");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (emit && last_out) |=> ((pend_ff == '0) && !in_done_ff && (em_row_ff == '0)))
      else $error("counters not restarted after the last output");
`endif

endmodule
